// ===== rtl/core/infix_to_postfix_converter_top_macros.svh =====
// Assertion macros for the infix to postfix converter.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ITP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("itp: invariant violated");
`define ITP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itp: implication violated");
`define ITP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itp: next-cycle check violated");
`else
`define ITP_ASSERT_ALWAYS(lbl, expr)
`define ITP_ASSERT_IMPLY(lbl, ante, cons)
`define ITP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/itp_pkg.sv =====
// Shared types, character codes and precedence helpers for the converter.
// No dependencies; used by the stack cell and the top level.
package itp_pkg;

  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_TERM    = 8'h00;

  // Precedence shifted up by one so it fits an unsigned field.
  localparam logic [2:0] RANK_NONE = 3'd0;
  localparam logic [2:0] RANK_ADD  = 3'd2;
  localparam logic [2:0] RANK_MUL  = 3'd3;
  localparam logic [2:0] RANK_POW  = 3'd4;

  localparam logic [1:0] ERR_OVERFLOW = 2'b01;
  localparam logic [1:0] ERR_UNMATCH  = 2'b10;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  function automatic logic [2:0] rank_of(input logic [7:0] c);
    logic [2:0] r;
    r = RANK_NONE;
    if (c == CH_CARET) begin
      r = RANK_POW;
    end else if (c == CH_STAR || c == CH_PERCENT || c == CH_SLASH) begin
      r = RANK_MUL;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      r = RANK_ADD;
    end
    return r;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

endpackage

// ===== rtl/core/itp_if.sv =====
// Valid/ready channel interfaces for the converter's input and result words.
// No dependencies.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] ch;
  modport source (output valid, cmd, ch, input ready);
  modport sink   (input valid, cmd, ch, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic [1:0] err_flags;
  modport source (output valid, out_char, last, err_flags, input ready);
  modport sink   (input valid, out_char, last, err_flags, output ready);
endinterface

// ===== rtl/core/itp_cell.sv =====
// One entry of the shifting operator stack.
// Depends on itp_pkg for the push/pop control struct.
module itp_cell (
  input  logic            clk,
  input  itp_pkg::stk_ctl_t ctl,
  input  logic [7:0]      from_above,
  input  logic [7:0]      from_below,
  output logic [7:0]      data
);

  logic [7:0] data_r;

  // A push moves every entry one cell deeper; a pop moves them back up.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data_r <= from_above;
    end else if (ctl.pop) begin
      data_r <= from_below;
    end
  end

  assign data = data_r;

endmodule

// ===== rtl/core/infix_to_postfix_converter_top.sv =====
// Infix to postfix converter: control sequencer over a chain of stack cells.
// Depends on itp_pkg, itp_if, itp_cell and the assertion macro header.
//
//  channel   | dir | payload                         | handshake
//  in_chan   | in  | cmd, ch                         | valid/ready
//  out_chan  | out | out_char, last, err_flags       | valid/ready
//
// An operand or '(' is accepted in the idle state and processed in the work state.
// An operator, ')' or end word stays in the work state until it has sent its words from the stack.
// The stack is a row of cells with the top in cell 0, one shift per cycle while the result side does not stall.
// Reset is synchronous, active low, and leaves the stack empty.
// A stalled result word holds the sequencer until it is taken.
`include "infix_to_postfix_converter_top_macros.svh"

module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  itp_in_if.sink         in_chan,
  itp_out_if.source      out_chan
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    sticky_r, sticky_nxt;
  logic          item_cmd_r;
  logic [7:0]    item_ch_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r;
  logic          out_last_r;
  logic [1:0]    out_err_r;

  logic [7:0]    cell_q [STACK_DEPTH];
  itp_pkg::stk_ctl_t ctl, ctl_g;

  logic       out_free, step, done;
  logic       emit, emit_last;
  logic [7:0] emit_char;
  logic [1:0] emit_err;
  logic       empty, full, one;
  logic [7:0] top_q, nxt_q;
  logic [2:0] rank_in, rank_top, rank_nxt;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [7:0] above, below;
      if (gi == 0) begin : g_head
        assign above = item_ch_r;
      end else begin : g_mid
        assign above = cell_q[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_tail
        assign below = itp_pkg::CH_TERM;
      end else begin : g_body
        assign below = cell_q[gi+1];
      end
      itp_cell u_cell (
        .clk        (clk),
        .ctl        (ctl_g),
        .from_above (above),
        .from_below (below),
        .data       (cell_q[gi])
      );
    end
  endgenerate

  assign top_q    = cell_q[0];
  assign nxt_q    = cell_q[1];
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign one      = (count_r == CW'(1));
  assign rank_in  = itp_pkg::rank_of(item_ch_r);
  assign rank_top = itp_pkg::rank_of(top_q);
  assign rank_nxt = itp_pkg::rank_of(nxt_q);
  assign out_free = !out_valid_r || out_chan.ready;
  assign step     = (state_r == ST_WORK) && out_free;

  always_comb begin
    ctl        = '0;
    emit       = 1'b0;
    emit_char  = top_q;
    emit_last  = 1'b0;
    emit_err   = 2'b00;
    done       = 1'b0;
    sticky_nxt = sticky_r;
    priority if (item_cmd_r) begin
      if (!empty) begin
        emit    = 1'b1;
        ctl.pop = 1'b1;
      end else begin
        emit       = 1'b1;
        emit_char  = itp_pkg::CH_TERM;
        emit_last  = 1'b1;
        emit_err   = sticky_r;
        sticky_nxt = 2'b00;
        done       = 1'b1;
      end
    end else if (itp_pkg::is_operand(item_ch_r)) begin
      emit      = 1'b1;
      emit_char = item_ch_r;
      emit_last = 1'b1;
      done      = 1'b1;
    end else if (item_ch_r == itp_pkg::CH_OPEN) begin
      if (full) begin
        sticky_nxt = sticky_r | itp_pkg::ERR_OVERFLOW;
      end else begin
        ctl.push = 1'b1;
      end
      done = 1'b1;
    end else if (item_ch_r == itp_pkg::CH_CLOSE) begin
      if (empty) begin
        sticky_nxt = sticky_r | itp_pkg::ERR_UNMATCH;
        done       = 1'b1;
      end else if (top_q == itp_pkg::CH_OPEN) begin
        ctl.pop = 1'b1;
        done    = 1'b1;
      end else begin
        emit      = 1'b1;
        ctl.pop   = 1'b1;
        emit_last = one || (nxt_q == itp_pkg::CH_OPEN);
      end
    end else begin
      if (!empty && (rank_in <= rank_top)) begin
        emit      = 1'b1;
        ctl.pop   = 1'b1;
        // The pop loop ends here when this is the last entry or the incoming operator outranks the next entry.
        emit_last = one || (rank_in > rank_nxt);
      end else begin
        if (full) begin
          sticky_nxt = sticky_r | itp_pkg::ERR_OVERFLOW;
        end else begin
          ctl.push = 1'b1;
        end
        done = 1'b1;
      end
    end
  end

  assign ctl_g = step ? ctl : '0;

  always_comb begin
    count_nxt = count_r;
    if (ctl_g.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl_g.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (step && done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sticky_r    <= 2'b00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        sticky_r <= sticky_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_cmd_r <= in_chan.cmd;
      item_ch_r  <= in_chan.ch;
    end
    if (step && emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
      out_err_r  <= emit_err;
    end
  end

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_char  = out_char_r;
  assign out_chan.last      = out_last_r;
  assign out_chan.err_flags = out_err_r;

  `ITP_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(STACK_DEPTH))
  `ITP_ASSERT_IMPLY(a_no_pop_empty, ctl_g.pop, !empty)
  `ITP_ASSERT_IMPLY(a_no_push_full, ctl_g.push, !full)
  `ITP_ASSERT_NEXT(a_term_clears, step && item_cmd_r && emit_last, empty && (sticky_r == 2'b00))

endmodule

// ===== bench/infix_to_postfix_converter_top_tb.sv =====
// Self-checking testbench for infix_to_postfix_converter_top.
// Directed words, then random expressions.
// Depends on itp_pkg, the itp_in_if/itp_out_if interfaces and the converter RTL.
module infix_to_postfix_converter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   STACK_DEPTH  = 32;
  localparam int   RANDOM_ITEMS = 220;
  localparam int   CYCLE_LIMIT  = 1_000_000;
  localparam int   MAX_REPORTS  = 10;
  localparam int   SETTLE_WAIT  = 40;
  localparam logic CMD_CHAR     = 1'b0;
  localparam logic CMD_END      = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] err;
  } postfix_word_t;

  typedef struct {
    logic          cmd;
    logic [7:0]    ch;
    int            reps;
    bit            typed;
    postfix_word_t word;
  } stim_row_t;

  localparam postfix_word_t NO_WORD = '0;

  logic clk;
  logic rst_n;

  itp_in_if  in_chan ();
  itp_out_if out_chan ();

  infix_to_postfix_converter_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Directed words. A typed word is used where the result is obvious.
  stim_row_t directed_rows [25] = '{
    '{CMD_CHAR, "a",                 1,  1'b1, '{"a", 1'b1, 2'b00}},
    '{CMD_END,  8'hFF,               1,  1'b1, '{itp_pkg::CH_TERM, 1'b1, 2'b00}},
    '{CMD_CHAR, itp_pkg::CH_CLOSE,   1,  1'b0, NO_WORD},
    '{CMD_END,  8'h00,               1,  1'b1,
      '{itp_pkg::CH_TERM, 1'b1, itp_pkg::ERR_UNMATCH}},
    '{CMD_CHAR, itp_pkg::CH_OPEN,    1,  1'b0, NO_WORD},
    '{CMD_CHAR, "9",                 1,  1'b1, '{"9", 1'b1, 2'b00}},
    '{CMD_CHAR, itp_pkg::CH_PLUS,    1,  1'b0, NO_WORD},
    '{CMD_CHAR, "Z",                 1,  1'b1, '{"Z", 1'b1, 2'b00}},
    '{CMD_CHAR, itp_pkg::CH_STAR,    1,  1'b0, NO_WORD},
    '{CMD_CHAR, "0",                 1,  1'b1, '{"0", 1'b1, 2'b00}},
    '{CMD_CHAR, itp_pkg::CH_CARET,   1,  1'b0, NO_WORD},
    '{CMD_CHAR, "z",                 1,  1'b1, '{"z", 1'b1, 2'b00}},
    '{CMD_CHAR, itp_pkg::CH_CARET,   1,  1'b0, NO_WORD},
    '{CMD_CHAR, "A",                 1,  1'b1, '{"A", 1'b1, 2'b00}},
    '{CMD_CHAR, itp_pkg::CH_PERCENT, 1,  1'b0, NO_WORD},
    '{CMD_CHAR, itp_pkg::CH_SLASH,   1,  1'b0, NO_WORD},
    '{CMD_CHAR, itp_pkg::CH_MINUS,   1,  1'b0, NO_WORD},
    '{CMD_CHAR, itp_pkg::CH_CLOSE,   1,  1'b0, NO_WORD},
    '{CMD_END,  8'h00,               1,  1'b0, NO_WORD},
    '{CMD_CHAR, 8'h00,               1,  1'b0, NO_WORD},
    '{CMD_CHAR, 8'hFF,               1,  1'b0, NO_WORD},
    '{CMD_CHAR, itp_pkg::CH_CLOSE,   1,  1'b0, NO_WORD},
    '{CMD_CHAR, itp_pkg::CH_OPEN,    34, 1'b0, NO_WORD},
    '{CMD_END,  8'h00,               1,  1'b0, NO_WORD},
    '{CMD_END,  8'h5A,               1,  1'b1, '{itp_pkg::CH_TERM, 1'b1, 2'b00}}
  };

  logic [7:0] op_entries [STACK_DEPTH];
  int         depth_now;
  logic [1:0] sticky_err;

  postfix_word_t step_words [$];
  postfix_word_t expected_words [$];

  int     fail_count;
  int     mismatch_count;
  int     words_checked;
  int     items_sent;
  int     expr_count;
  int     overflow_ends;
  int     unmatch_ends;
  int     recv_stall;
  bit     send_no_idle;
  bit     recv_no_idle;
  bit     paused;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycles,
               expected_words.size());
      $display("FAIL infix_to_postfix_converter_top");
      $finish;
    end
  end

  function automatic int op_precedence(logic [7:0] c);
    unique case (c)
      itp_pkg::CH_CARET:                                        return 3;
      itp_pkg::CH_STAR, itp_pkg::CH_PERCENT, itp_pkg::CH_SLASH: return 2;
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS:                      return 1;
      default:                                                  return -1;
    endcase
  endfunction

  function automatic bit is_alnum_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z");
  endfunction

  task automatic emit_word(logic [7:0] c, logic [1:0] e);
    step_words.push_back('{ch: c, last: 1'b0, err: e});
  endtask

  task automatic push_entry(logic [7:0] c);
    if (depth_now >= STACK_DEPTH) begin
      sticky_err |= itp_pkg::ERR_OVERFLOW;
    end else begin
      op_entries[depth_now] = c;
      depth_now++;
    end
  endtask

  // Runs one input word through the operator stack and leaves its postfix words in step_words.
  task automatic step_converter(logic cmd, logic [7:0] c);
    int            p;
    postfix_word_t w;
    step_words.delete();
    if (cmd == CMD_END) begin
      while (depth_now > 0) begin
        depth_now--;
        emit_word(op_entries[depth_now], 2'b00);
      end
      emit_word(itp_pkg::CH_TERM, sticky_err);
      sticky_err = 2'b00;
    end else if (is_alnum_char(c)) begin
      emit_word(c, 2'b00);
    end else if (c == itp_pkg::CH_OPEN) begin
      push_entry(c);
    end else if (c == itp_pkg::CH_CLOSE) begin
      while (depth_now > 0 && op_entries[depth_now-1] != itp_pkg::CH_OPEN) begin
        depth_now--;
        emit_word(op_entries[depth_now], 2'b00);
      end
      if (depth_now > 0) depth_now--;
      else sticky_err |= itp_pkg::ERR_UNMATCH;
    end else begin
      p = op_precedence(c);
      while (depth_now > 0 && p <= op_precedence(op_entries[depth_now-1])) begin
        depth_now--;
        emit_word(op_entries[depth_now], 2'b00);
      end
      push_entry(c);
    end
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic cmd, logic [7:0] c, bit typed, postfix_word_t typed_word);
    int gap;
    if ($urandom_range(0, 15) == 0) send_no_idle = !send_no_idle;
    gap = send_no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.cmd   = cmd;
    in_chan.ch    = c;
    do @(posedge clk); while (!in_chan.ready);
    step_converter(cmd, c);
    if (typed) expected_words.push_back(typed_word);
    else foreach (step_words[i]) expected_words.push_back(step_words[i]);
    items_sent++;
    @(negedge clk);
  endtask

  // Now and then a token is swapped for a random byte or a stray end word.
  task automatic send_token(logic [7:0] c);
    int pick;
    pick = $urandom_range(0, 39);
    if (pick < 3) send_word(CMD_CHAR, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
    else if (pick == 3) send_word(CMD_END, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
    else send_word(CMD_CHAR, c, 1'b0, NO_WORD);
  endtask

  function automatic logic [7:0] pick_operand();
    unique case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return 8'("A" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    unique case ($urandom_range(0, 5))
      0:       return itp_pkg::CH_CARET;
      1:       return itp_pkg::CH_STAR;
      2:       return itp_pkg::CH_PERCENT;
      3:       return itp_pkg::CH_SLASH;
      4:       return itp_pkg::CH_PLUS;
      default: return itp_pkg::CH_MINUS;
    endcase
  endfunction

  task automatic gen_expression();
    int terms;
    int nest;
    terms = $urandom_range(1, 8);
    nest  = 0;
    expr_count++;
    // A rare long run of open parens can drive the stack into overflow.
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(28, 40)) send_word(CMD_CHAR, itp_pkg::CH_OPEN, 1'b0, NO_WORD);
    end
    for (int t = 0; t < terms; t++) begin
      while (nest < 6 && $urandom_range(0, 3) == 0) begin
        send_token(itp_pkg::CH_OPEN);
        nest++;
      end
      send_token(pick_operand());
      while (nest > 0 && $urandom_range(0, 2) == 0) begin
        send_token(itp_pkg::CH_CLOSE);
        nest--;
      end
      if (t < terms - 1) send_token(pick_operator());
    end
    if ($urandom_range(0, 3) != 0) begin
      while (nest > 0) begin
        send_token(itp_pkg::CH_CLOSE);
        nest--;
      end
    end
    if ($urandom_range(0, 7) == 0) send_token(itp_pkg::CH_CLOSE);
    send_word(CMD_END, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
  endtask

  task automatic drain_results();
    in_chan.valid = 1'b0;
    while (expected_words.size() > 0) @(negedge clk);
  endtask

  task automatic check_word(postfix_word_t got);
    postfix_word_t want;
    words_checked++;
    if (expected_words.size() == 0) begin
      fail_count++;
      if (mismatch_count < MAX_REPORTS)
        $display("Unexpected word: char=%02h last=%0b err=%0b", got.ch, got.last, got.err);
      mismatch_count++;
      return;
    end
    want = expected_words.pop_front();
    if (want.ch == itp_pkg::CH_TERM && want.last) begin
      if (want.err[0]) overflow_ends++;
      if (want.err[1]) unmatch_ends++;
    end
    if (got.ch !== want.ch || got.last !== want.last || got.err !== want.err) begin
      fail_count++;
      if (mismatch_count < MAX_REPORTS)
        $display({"Mismatch on word %0d: expected char=%02h last=%0b err=%0b, ",
                  "got char=%02h last=%0b err=%0b"},
                 words_checked, want.ch, want.last, want.err, got.ch, got.last, got.err);
      mismatch_count++;
    end
  endtask

  initial begin
    out_chan.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_no_idle = !recv_no_idle;
      recv_stall = recv_no_idle ? 0 : $urandom_range(0, 14);
      if (recv_stall > 0) begin
        out_chan.ready = 1'b0;
        repeat (recv_stall) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      check_word('{ch: out_chan.out_char, last: out_chan.last, err: out_chan.err_flags});
      @(negedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.cmd   = CMD_CHAR;
    in_chan.ch    = 8'h00;
    depth_now     = 0;
    sticky_err    = 2'b00;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++)
        send_word(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].typed,
                  directed_rows[i].word);
    end
    drain_results();

    while (items_sent < RANDOM_ITEMS + 60) begin
      gen_expression();
      // Halfway through, hold the input until the output side has caught up.
      if (!paused && items_sent >= 60 + RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (SETTLE_WAIT) @(negedge clk);

    $display("Sent %0d input words (%0d random expressions); checked %0d postfix words.",
             items_sent, expr_count, words_checked);
    $display("Terminators seen with overflow: %0d, with unmatched close paren: %0d.",
             overflow_ends, unmatch_ends);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("PASS infix_to_postfix_converter_top");
    end else begin
      $display("%0d failures, %0d words left over", fail_count, expected_words.size());
      $display("FAIL infix_to_postfix_converter_top");
    end
    $finish;
  end

endmodule
